/* design/spmm_pkg.sv */
// ----------------------------------------------------------------------------
// spmm_pkg
// Shared types and constants for the per-slot period min/max/mean rollup.
// ----------------------------------------------------------------------------
package spmm_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = 6;
  localparam int SPP       = 60;                  // samples per period
  localparam int CNT_W     = $clog2(SPP + 1);
  localparam int OUT_CNT_W = 6;
  localparam int RD_W      = 16;
  localparam int SUM_W     = 22;
  localparam int DVD_W     = SUM_W + 1;
  localparam int DSR_W     = CNT_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = 1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic signed [RD_W-1:0] NO_VALUE  = 16'sh8000;
  localparam logic signed [RD_W-1:0] MIN_START = 16'sh7FFF;
  localparam logic signed [RD_W-1:0] MAX_START = 16'sh8001;

  typedef struct packed {
    logic                   op;
    logic [SLOT_W-1:0]      slot;
    logic signed [RD_W-1:0] reading;
  } cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic signed [RD_W-1:0]  mn;
    logic signed [RD_W-1:0]  mx;
  } entry_t;

  localparam entry_t ENTRY_RST = '{sum: '0, cnt: '0, mn: MIN_START, mx: MAX_START};

  typedef struct packed {
    logic [SLOT_W-1:0]      slot;
    logic [OUT_CNT_W-1:0]   total;
    logic signed [RD_W-1:0] mean;
    logic signed [RD_W-1:0] mn;
    logic signed [RD_W-1:0] mx;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DIV,
    B_OUT
  } back_st_t;

endpackage

/* design/spmm_ifs.sv */
// ----------------------------------------------------------------------------
// spmm channel interfaces
// Valid/ready channels for the command words and the rollup words.
// ----------------------------------------------------------------------------
interface spmm_in_if import spmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SLOT_W-1:0]      slot;
  logic signed [RD_W-1:0] reading;

  modport source (output valid, op, slot, reading, input ready);
  modport sink   (input valid, op, slot, reading, output ready);
endinterface

interface spmm_out_if import spmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SLOT_W-1:0]      out_slot;
  logic [OUT_CNT_W-1:0]   sample_total;
  logic signed [RD_W-1:0] mean_value;
  logic signed [RD_W-1:0] min_value;
  logic signed [RD_W-1:0] max_value;

  modport source (output valid, out_slot, sample_total, mean_value, min_value, max_value,
                  input ready);
  modport sink   (input valid, out_slot, sample_total, mean_value, min_value, max_value,
                  output ready);
endinterface

/* design/spmm_front.sv */
// ----------------------------------------------------------------------------
// spmm_front
// Accepts command words, drops invalid samples, stages the rest for the queue.
// ----------------------------------------------------------------------------
module spmm_front import spmm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic signed [RD_W-1:0] in_reading,
  output logic                   push_valid,
  input  logic                   push_ready,
  output cmd_t                   push_cmd
);

  logic st_valid_r, st_valid_nxt;
  cmd_t st_cmd_r;
  logic in_fire;
  logic keep;

  assign in_ready   = !st_valid_r || push_ready;
  assign in_fire    = in_valid && in_ready;
  // readouts always pass; samples only when the reading is not the invalid marker
  assign keep       = (in_op == OP_READ) || (in_reading != NO_VALUE);
  assign push_valid = st_valid_r;
  assign push_cmd   = st_cmd_r;

  always_comb begin
    st_valid_nxt = st_valid_r && !push_ready;
    if (in_fire) begin
      st_valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_cmd_r <= '{op: in_op, slot: in_slot, reading: in_reading};
    end
  end

endmodule

/* design/spmm_queue.sv */
// ----------------------------------------------------------------------------
// spmm_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module spmm_queue import spmm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_cmd
);

  cmd_t              ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, rp_r;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              wr_fire, rd_fire;

  assign wr_ready = (cnt_r != Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_pop && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({wr_fire, rd_fire})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_fire) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_fire) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

endmodule

/* design/spmm_div.sv */
// ----------------------------------------------------------------------------
// spmm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spmm_div import spmm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W:0]    rem_sh;
  logic              ge;
  logic [DSR_W:0]    rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_r});
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  assign rsp = '{done: done_r, quot: dvd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the dividend register shifts left and collects quotient bits at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

endmodule

/* design/spmm_back.sv */
// ----------------------------------------------------------------------------
// spmm_back
// Slot store with read-modify-write for samples and readout with divider.
// ----------------------------------------------------------------------------
module spmm_back import spmm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  cmd_t     q_cmd,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res
);

  back_st_t st_r, st_nxt;

  entry_t mem_r [SLOTS];
  logic   vld_r [SLOTS];
  entry_t rd_r;
  logic   rd_vld_r;
  cmd_t   cmd_r;
  res_t   wk_r;
  logic   wk_neg_r;
  res_t   res_r;
  logic   out_valid_r;

  entry_t ent;
  entry_t upd;
  logic   is_read;
  logic   full;
  logic   wr_en;
  logic   clr_en;
  logic   ld_out;
  logic   out_free;
  logic   div_start;
  logic   sum_neg;
  logic [SUM_W-1:0] mag;
  logic signed [SUM_W-1:0] rd_ext;
  logic [RD_W-1:0] q16;

  // a slot that was never written since reset or readout reads as cleared
  assign ent      = rd_vld_r ? rd_r : ENTRY_RST;
  assign is_read  = (cmd_r.op == OP_READ);
  assign full     = (ent.cnt >= CNT_W'(SPP));
  assign out_free = !out_valid_r || out_ready;
  assign sum_neg  = ent.sum[SUM_W-1];
  assign mag      = sum_neg ? SUM_W'(-ent.sum) : SUM_W'(ent.sum);
  assign rd_ext   = SUM_W'(cmd_r.reading);
  assign q16      = div_rsp.quot[RD_W-1:0];

  always_comb begin
    upd     = ent;
    upd.sum = ent.sum + rd_ext;
    upd.cnt = ent.cnt + 1'b1;
    if (cmd_r.reading < ent.mn) begin
      upd.mn = cmd_r.reading;
    end
    if (cmd_r.reading > ent.mx) begin
      upd.mx = cmd_r.reading;
    end
  end

  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = {mag, 1'b0} + DVD_W'(ent.cnt);
    div_req.divisor  = {ent.cnt, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    clr_en    = 1'b0;
    ld_out    = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (is_read) begin
          clr_en = 1'b1;
          if (ent.cnt == '0) begin
            st_nxt = B_OUT;
          end else begin
            div_start = 1'b1;
            st_nxt    = B_DIV;
          end
        end else begin
          wr_en  = !full;
          st_nxt = B_IDLE;
        end
      end
      B_DIV: begin
        if (div_rsp.done) begin
          st_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          ld_out = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // slot store: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= mem_r[q_cmd.slot];
    end
    if (wr_en) begin
      mem_r[cmd_r.slot] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rd_vld_r <= vld_r[q_cmd.slot];
      end
      if (wr_en) begin
        vld_r[cmd_r.slot] <= 1'b1;
      end else if (clr_en) begin
        vld_r[cmd_r.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (clr_en) begin
      wk_neg_r   <= sum_neg;
      wk_r.slot  <= cmd_r.slot;
      wk_r.total <= ent.cnt[OUT_CNT_W-1:0];
      if (ent.cnt == '0) begin
        wk_r.mean <= NO_VALUE;
        wk_r.mn   <= NO_VALUE;
        wk_r.mx   <= NO_VALUE;
      end else begin
        wk_r.mean <= '0;
        wk_r.mn   <= ent.mn;
        wk_r.mx   <= ent.mx;
      end
    end
    if (st_r == B_DIV && div_rsp.done) begin
      wk_r.mean <= wk_neg_r ? RD_W'(-q16) : q16;
    end
    if (ld_out) begin
      res_r <= wk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

/* design/sensor_period_min_max_mean_top.sv */
// Sample word: front stage, queue pop and registered read, then the store write;
//   the back takes no new sample until the slot store read-modify-write is done.
// Readout word: the back is busy until the result word is loaded, through the
//   23-step bit-serial mean divider, which an empty slot skips.
// Reset: synchronous, active low; per-slot valid bits all clear on reset, so every slot
//   reads as empty and words are accepted right after reset.
// ----------------------------------------------------------------------------
// sensor_period_min_max_mean_top
// Per-slot period rollup of count, rounded mean, minimum and maximum.
// ----------------------------------------------------------------------------
module sensor_period_min_max_mean_top import spmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  spmm_in_if.sink           in_if,
  spmm_out_if.source        out_if
);

  logic     push_valid;
  logic     push_ready;
  cmd_t     push_cmd;
  logic     q_valid;
  logic     q_pop;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  spmm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_op      (in_if.op),
    .in_slot    (in_if.slot),
    .in_reading (in_if.reading),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  spmm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  spmm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  spmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.out_slot     = res.slot;
  assign out_if.sample_total = res.total;
  assign out_if.mean_value   = res.mean;
  assign out_if.min_value    = res.mn;
  assign out_if.max_value    = res.mx;

endmodule

/* design/spmm_chk.sv */
// ----------------------------------------------------------------------------
// spmm_chk
// Port-level checks on the rollup word channel.
// ----------------------------------------------------------------------------
module spmm_chk import spmm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SLOT_W-1:0]      out_slot,
  input logic [OUT_CNT_W-1:0]   sample_total,
  input logic signed [RD_W-1:0] mean_value,
  input logic signed [RD_W-1:0] min_value,
  input logic signed [RD_W-1:0] max_value
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("rollup word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_slot) && $stable(sample_total)
      && $stable(mean_value) && $stable(min_value) && $stable(max_value))
    else $error("rollup word changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_total == '0 |->
      mean_value == NO_VALUE && min_value == NO_VALUE && max_value == NO_VALUE)
    else $error("empty slot readout without marker values");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sample_total <= OUT_CNT_W'(SPP))
    else $error("sample count above period limit");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_total != '0 |->
      min_value <= mean_value && mean_value <= max_value)
    else $error("mean outside min/max range");

endmodule

bind sensor_period_min_max_mean_top spmm_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_slot     (out_if.out_slot),
  .sample_total (out_if.sample_total),
  .mean_value   (out_if.mean_value),
  .min_value    (out_if.min_value),
  .max_value    (out_if.max_value)
);
